@@ hw/rtl/pkcm_pkg.sv @@
// shared types and constants for the power key and charge monitor
`default_nettype none

package pkcm_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  localparam logic [CfgIdxW-1:0] CFG_BOOT_REASON    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DISPLAY_PERIOD = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_TIMEOUT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NO_BATTERY     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_ONE      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_TWO      = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_THREE    = 3'd7;

  // register reset values
  localparam logic [1:0]  RST_BOOT_REASON    = 2'd0;
  localparam logic [3:0]  RST_LONG_PRESS     = 4'd6;
  localparam logic [5:0]  RST_DISPLAY_PERIOD = 6'd20;
  localparam logic [5:0]  RST_SCREEN_TIMEOUT = 6'd30;
  localparam logic [11:0] RST_NO_BATTERY     = 12'd450;
  localparam logic [13:0] RST_LEVEL_ONE      = 14'd7414;
  localparam logic [13:0] RST_LEVEL_TWO      = 14'd7682;
  localparam logic [13:0] RST_LEVEL_THREE    = 14'd8282;

  // boot reason code that skips waiting
  localparam logic [1:0] BOOT_REASON_REBOOT = 2'd2;

  // outcome codes
  localparam logic [1:0] OUTCOME_WAIT     = 2'd0;
  localparam logic [1:0] OUTCOME_BOOT     = 2'd1;
  localparam logic [1:0] OUTCOME_POWEROFF = 2'd2;
  localparam logic [1:0] OUTCOME_REBOOT   = 2'd3;

  // led bits
  localparam logic [3:0] LED_OFF      = 4'h0;
  localparam logic [3:0] LED_CHARGING = 4'h2;
  localparam logic [3:0] LED_CHARGED  = 4'h4;

  // voltage scaling: mv = ((adc*3300)/4095*509)/200
  localparam logic [11:0] VOLT_MUL   = 12'd3300;
  localparam logic [11:0] VOLT_DIV   = 12'd4095;
  localparam logic [8:0]  DIV_MUL    = 9'd509;
  // floor(z/25) = (z*335545) >> 23 for z < 2^18
  localparam logic [18:0] RECIP_25   = 19'd335545;
  localparam int unsigned RECIP_SHFT = 23;

  typedef struct packed {
    logic        button_level;
    logic        charge_pin;
    logic        fault_pin;
    logic [11:0] presence_adc;
    logic [11:0] voltage_adc;
  } pkcm_req_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic       screen_on;
    logic [3:0] led_pattern;
    logic       redraw;
    logic       frame_shown;
    logic [1:0] bars_shown;
  } pkcm_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mul_en;
    logic scale_en;
    logic recip_en;
    logic commit;
  } pkcm_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/power_key_charge_monitor_core.sv @@
// top level of the power key and charge monitor
`default_nettype none

// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+----------------------------
// in        | input     | in_valid_i / in_stall_o  | in_req_i  (pkcm_req_t)
// out       | output    | out_valid_o / out_stall_i| out_rsp_o (pkcm_rsp_t)
// cfg       | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// each request goes through capture, three voltage scaling steps
// (12x12 multiply, divide by 4095 and multiply by 509, reciprocal multiply
// for the divide by 200), then the state update into the output register
// the next request is taken in the cycle after the update
// reset is asynchronous and active low; config registers and tick state
// come up at their documented values
// a stalled output holds the update step; a new request may be taken
// while the last result still waits in the output register

module power_key_charge_monitor_core
  import pkcm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire pkcm_req_t           in_req_i,
  // result channel
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      pkcm_rsp_t           out_rsp_o,
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  // sequencing commands from controller to datapath
  pkcm_cmd_t cmd;

  // state machine: request accept, scaling steps, commit
  pkcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // config registers, voltage math, press and charge state
  pkcm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/pkcm_ctrl.sv @@
// sequencing state machine for the power key and charge monitor
`default_nettype none

module pkcm_ctrl
  import pkcm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      pkcm_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_SCALE  = 5'b00100,
    S_RECIP  = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_busy;

  assign out_busy = out_valid_q & out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale_en = 1'b1;
        state_d        = S_RECIP;
      end
      S_RECIP: begin
        cmd_o.recip_en = 1'b1;
        state_d        = S_COMMIT;
      end
      S_COMMIT: begin
        // wait for the output register to free up
        if (!out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_commit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !out_busy)
    else $error("commit while output register held");

  a_capture_to_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> ##2 state_q == S_RECIP ##1 state_q == S_COMMIT)
    else $error("request did not reach commit after three steps");

  a_valid_from_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.commit))
    else $error("output valid rose without commit");

endmodule

`default_nettype wire

@@ hw/rtl/pkcm_datapath.sv @@
// config registers, voltage scaling pipeline and tick state update
`default_nettype none

module pkcm_datapath
  import pkcm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pkcm_cmd_t           cmd_i,
  input  wire pkcm_req_t           in_req_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output      pkcm_rsp_t           out_rsp_o
);

  // configuration
  logic [1:0]  boot_reason_q;
  logic [3:0]  long_press_q;
  logic [5:0]  period_q;
  logic [5:0]  timeout_q;
  logic [11:0] no_batt_q;
  logic [13:0] lvl_one_q;
  logic [13:0] lvl_two_q;
  logic [13:0] lvl_three_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_reason_q <= RST_BOOT_REASON;
      long_press_q  <= RST_LONG_PRESS;
      period_q      <= RST_DISPLAY_PERIOD;
      timeout_q     <= RST_SCREEN_TIMEOUT;
      no_batt_q     <= RST_NO_BATTERY;
      lvl_one_q     <= RST_LEVEL_ONE;
      lvl_two_q     <= RST_LEVEL_TWO;
      lvl_three_q   <= RST_LEVEL_THREE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOOT_REASON:    boot_reason_q <= cfg_wdata_i[1:0];
        CFG_LONG_PRESS:     long_press_q  <= cfg_wdata_i[3:0];
        CFG_DISPLAY_PERIOD: period_q      <= cfg_wdata_i[5:0];
        CFG_SCREEN_TIMEOUT: timeout_q     <= cfg_wdata_i[5:0];
        CFG_NO_BATTERY:     no_batt_q     <= cfg_wdata_i[11:0];
        CFG_LEVEL_ONE:      lvl_one_q     <= cfg_wdata_i;
        CFG_LEVEL_TWO:      lvl_two_q     <= cfg_wdata_i;
        CFG_LEVEL_THREE:    lvl_three_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // captured request and scaling pipeline
  pkcm_req_t   req_q;
  logic [23:0] x_q;
  logic [20:0] y_q;
  logic [36:0] prod_q;

  // x / 4095: estimate x >> 12, remainder stays below twice the divisor
  logic [11:0] q0;
  logic [12:0] rem;
  logic [11:0] quot;
  logic [13:0] mv;

  assign q0   = x_q[23:12];
  assign rem  = {1'b0, x_q[11:0]} + {1'b0, q0};
  assign quot = (rem >= {1'b0, VOLT_DIV}) ? q0 + 12'd1 : q0;
  assign mv   = prod_q[RECIP_SHFT +: 14];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_req_i;
    end
    if (cmd_i.mul_en) begin
      x_q <= 24'(req_q.voltage_adc) * 24'(VOLT_MUL);
    end
    if (cmd_i.scale_en) begin
      y_q <= 21'(quot) * 21'(DIV_MUL);
    end
    if (cmd_i.recip_en) begin
      // divide by 8 by dropping bits, then by 25 through the reciprocal
      prod_q <= 37'(y_q[20:3]) * 37'(RECIP_25);
    end
  end

  // tick state
  logic       sampling_q, sampling_d;
  logic [3:0] press_cnt_q, press_cnt_d;
  logic       latched_q, latched_d;
  logic       screen_q, screen_d;
  logic [5:0] tick_q, tick_d;
  logic [5:0] refresh_q, refresh_d;
  logic       fault_ref_q, fault_ref_d;
  logic [1:0] anim_q, anim_d;
  logic [3:0] led_q, led_d;
  logic [1:0] outcome_q, outcome_d;
  logic       redraw, frame, do_pass, released, charging;
  logic [1:0] bars;
  logic [1:0] level;

  always_comb begin
    if (mv <= lvl_one_q) begin
      level = 2'd0;
    end else if (mv <= lvl_two_q) begin
      level = 2'd1;
    end else if (mv <= lvl_three_q) begin
      level = 2'd2;
    end else begin
      level = 2'd3;
    end
  end

  always_comb begin
    sampling_d  = sampling_q;
    press_cnt_d = press_cnt_q;
    latched_d   = latched_q;
    screen_d    = screen_q;
    tick_d      = tick_q;
    refresh_d   = refresh_q;
    fault_ref_d = fault_ref_q;
    anim_d      = anim_q;
    led_d       = led_q;
    outcome_d   = outcome_q;
    redraw      = 1'b0;
    frame       = 1'b0;
    bars        = 2'd0;
    do_pass     = 1'b0;
    released    = 1'b0;
    charging    = 1'b0;

    if (outcome_q != OUTCOME_WAIT) begin
      // decided, hold everything
    end else if (boot_reason_q == BOOT_REASON_REBOOT) begin
      outcome_d = OUTCOME_REBOOT;
    end else if (sampling_q) begin
      if (!req_q.button_level) begin
        press_cnt_d = press_cnt_q + 4'd1;
        if (press_cnt_d >= long_press_q) begin
          outcome_d  = OUTCOME_BOOT;
          screen_d   = 1'b0;
          sampling_d = 1'b0;
        end
      end else begin
        // release tick also serves as the pass tick
        sampling_d = 1'b0;
        do_pass    = 1'b1;
        released   = 1'b1;
        charging   = latched_q;
      end
    end else if (!req_q.button_level) begin
      sampling_d  = 1'b1;
      press_cnt_d = 4'd0;
      latched_d   = req_q.charge_pin;
      if (long_press_q == 4'd0) begin
        outcome_d  = OUTCOME_BOOT;
        screen_d   = 1'b0;
        sampling_d = 1'b0;
      end
    end else begin
      latched_d = req_q.charge_pin;
      do_pass   = 1'b1;
      charging  = req_q.charge_pin;
    end

    if (do_pass) begin
      if (released && !charging) begin
        screen_d  = ~screen_d;
        refresh_d = 6'd0;
      end
      if (charging) begin
        outcome_d = OUTCOME_POWEROFF;
      end else begin
        if (tick_q == 6'd0) begin
          fault_ref_d = req_q.fault_pin;
        end
        tick_d = tick_q + 6'd1;
        if (tick_d >= period_q) begin
          if (screen_d) begin
            redraw = 1'b1;
            if (req_q.presence_adc < no_batt_q) begin
              screen_d = 1'b0;
            end else begin
              case (anim_q)
                2'd0: begin
                  led_d  = LED_CHARGING;
                  frame  = 1'b1;
                  anim_d = 2'd1;
                end
                2'd1: begin
                  bars   = 2'd1;
                  anim_d = 2'd2;
                end
                2'd2: begin
                  bars   = 2'd2;
                  anim_d = 2'd3;
                end
                default: begin
                  bars   = 2'd3;
                  anim_d = level;
                  led_d  = (level == 2'd3) ? LED_CHARGED : LED_CHARGING;
                end
              endcase
            end
            refresh_d = refresh_d + 6'd1;
          end
          if (fault_ref_d != req_q.fault_pin) begin
            screen_d = 1'b0;
            led_d    = LED_OFF;
          end
          tick_d = 6'd0;
        end
        if (refresh_d >= timeout_q) begin
          screen_d  = 1'b0;
          refresh_d = 6'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sampling_q  <= 1'b0;
      press_cnt_q <= 4'd0;
      latched_q   <= 1'b0;
      screen_q    <= 1'b1;
      tick_q      <= 6'd0;
      refresh_q   <= 6'd0;
      fault_ref_q <= 1'b0;
      anim_q      <= 2'd0;
      led_q       <= LED_OFF;
      outcome_q   <= OUTCOME_WAIT;
    end else if (cmd_i.commit) begin
      sampling_q  <= sampling_d;
      press_cnt_q <= press_cnt_d;
      latched_q   <= latched_d;
      screen_q    <= screen_d;
      tick_q      <= tick_d;
      refresh_q   <= refresh_d;
      fault_ref_q <= fault_ref_d;
      anim_q      <= anim_d;
      led_q       <= led_d;
      outcome_q   <= outcome_d;
    end
  end

  pkcm_rsp_t rsp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q.outcome     <= outcome_d;
      rsp_q.screen_on   <= screen_d;
      rsp_q.led_pattern <= led_d;
      rsp_q.redraw      <= redraw;
      rsp_q.frame_shown <= frame;
      rsp_q.bars_shown  <= bars;
    end
  end

  assign out_rsp_o = rsp_q;

  a_outcome_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outcome_q != OUTCOME_WAIT) |=> outcome_q == $past(outcome_q))
    else $error("decided outcome changed");

  a_led_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(led_q))
    else $error("more than one led lit");

  a_boot_dark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outcome_q == OUTCOME_BOOT) |-> !screen_q)
    else $error("screen on after boot");

endmodule

`default_nettype wire
